### design/cau_pkg.sv
// Shared operation codes, status codes and control types of the complex arithmetic unit.
package cau_pkg;

  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  // Operation selector codes.
  localparam logic [KIND_W-1:0] KIND_ADD   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SUB   = 3'd1;
  localparam logic [KIND_W-1:0] KIND_MUL   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_NEG   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_RECIP = 3'd4;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_SAT  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DIV0 = 2'd2;

  // Control that travels with each item through the pipeline.
  typedef struct packed {
    logic              valid;
    logic [KIND_W-1:0] kind;
  } cau_ctl_t;

endpackage

### design/cau_front.sv
// Front pipeline: operand register, products and sums, exact combined values and magnitude.
module cau_front #(
  parameter int W = 16
) (
  input  logic                 clk,
  input  logic                 rst,
  input  cau_pkg::cau_ctl_t    in_ctl,
  input  logic signed [W-1:0]  a_re,
  input  logic signed [W-1:0]  a_im,
  input  logic signed [W-1:0]  b_re,
  input  logic signed [W-1:0]  b_im,
  output cau_pkg::cau_ctl_t    out_ctl,
  output logic signed [2*W:0]  v_re,
  output logic signed [2*W:0]  v_im,
  output logic [2*W-1:0]       den,
  output logic [W-1:0]         amag_re,
  output logic [W-1:0]         amag_im
);

  localparam int PW = 2 * W;
  localparam int VW = 2 * W + 1;

  cau_pkg::cau_ctl_t   ctl_a, ctl_b;
  logic signed [W-1:0] ar, ai, br, bi;

  logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, sq_r, sq_i;
  logic signed [W:0]    lin_re, lin_im;
  logic [W-1:0]         mag_re_b, mag_im_b;

  logic signed [W:0]    lin_re_next, lin_im_next;
  logic signed [W:0]    ar_x, ai_x, br_x, bi_x;
  logic signed [VW-1:0] v_re_next, v_im_next;

  // Stage A: capture operands.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_a.valid <= 1'b0;
    end else begin
      ctl_a.valid <= in_ctl.valid;
    end
    ctl_a.kind <= in_ctl.kind;
    ar <= a_re;
    ai <= a_im;
    br <= b_re;
    bi <= b_im;
  end

  assign ar_x = {ar[W-1], ar};
  assign ai_x = {ai[W-1], ai};
  assign br_x = {br[W-1], br};
  assign bi_x = {bi[W-1], bi};

  // Linear result for add, subtract and negate.
  always_comb begin
    case (ctl_a.kind)
      cau_pkg::KIND_ADD: begin
        lin_re_next = ar_x + br_x;
        lin_im_next = ai_x + bi_x;
      end
      cau_pkg::KIND_SUB: begin
        lin_re_next = ar_x - br_x;
        lin_im_next = ai_x - bi_x;
      end
      default: begin
        lin_re_next = -ar_x;
        lin_im_next = -ai_x;
      end
    endcase
  end

  // Stage B: the six products, the linear result and the magnitude of a.
  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_b.valid <= 1'b0;
    end else begin
      ctl_b.valid <= ctl_a.valid;
    end
    ctl_b.kind <= ctl_a.kind;
    p_rr       <= ar * br;
    p_ii       <= ai * bi;
    p_ri       <= ar * bi;
    p_ir       <= ai * br;
    sq_r       <= ar * ar;
    sq_i       <= ai * ai;
    lin_re     <= lin_re_next;
    lin_im     <= lin_im_next;
    mag_re_b   <= ar[W-1] ? W'(-ar) : W'(ar);
    mag_im_b   <= ai[W-1] ? W'(-ai) : W'(ai);
  end

  // Select the exact unscaled value of each part.
  always_comb begin
    case (ctl_b.kind)
      cau_pkg::KIND_MUL: begin
        v_re_next = VW'(p_rr) - VW'(p_ii);
        v_im_next = VW'(p_ri) + VW'(p_ir);
      end
      cau_pkg::KIND_ADD, cau_pkg::KIND_SUB, cau_pkg::KIND_NEG: begin
        v_re_next = VW'(lin_re);
        v_im_next = VW'(lin_im);
      end
      default: begin
        v_re_next = '0;
        v_im_next = '0;
      end
    endcase
  end

  // Stage C: combined values and the squared magnitude.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_ctl.valid <= 1'b0;
    end else begin
      out_ctl.valid <= ctl_b.valid;
    end
    out_ctl.kind <= ctl_b.kind;
    v_re         <= v_re_next;
    v_im         <= v_im_next;
    den          <= PW'($unsigned(sq_r)) + PW'($unsigned(sq_i));
    amag_re      <= mag_re_b;
    amag_im      <= mag_im_b;
  end

endmodule

### design/cau_div_step.sv
// One restoring division stage for both parts, producing one quotient bit each.
module cau_div_step #(
  parameter int W     = 16,
  parameter int RW    = 48,
  parameter int DW    = 32,
  parameter int SHIFT = 0,
  parameter int SW    = 8
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic [RW-1:0] in_rem_re,
  input  logic [RW-1:0] in_rem_im,
  input  logic [W-1:0]  in_q_re,
  input  logic [W-1:0]  in_q_im,
  input  logic [DW-1:0] in_den,
  input  logic [SW-1:0] in_side,
  output logic          out_valid,
  output logic [RW-1:0] out_rem_re,
  output logic [RW-1:0] out_rem_im,
  output logic [W-1:0]  out_q_re,
  output logic [W-1:0]  out_q_im,
  output logic [DW-1:0] out_den,
  output logic [SW-1:0] out_side
);

  logic [RW-1:0] dsh;
  logic          take_re, take_im;
  logic [W-1:0]  qbit;

  assign dsh     = RW'(in_den) << SHIFT;
  assign take_re = in_rem_re >= dsh;
  assign take_im = in_rem_im >= dsh;
  assign qbit    = W'(1) << SHIFT;

  // Subtract the shifted divisor where it fits and set the quotient bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= in_valid;
    end
    out_rem_re <= take_re ? in_rem_re - dsh : in_rem_re;
    out_rem_im <= take_im ? in_rem_im - dsh : in_rem_im;
    out_q_re   <= take_re ? (in_q_re | qbit) : in_q_re;
    out_q_im   <= take_im ? (in_q_im | qbit) : in_q_im;
    out_den    <= in_den;
    out_side   <= in_side;
  end

endmodule

### design/complex_arithmetic_unit.sv
// Top level of the complex arithmetic unit: front stages, clamp stage, divider chain, output.
// Every operation takes the same path from the start transfer to the done strobe.
// Throughput: one operation per cycle; busy is always low.
// The reciprocal runs through DATA_WIDTH restoring divider stages, which set the depth.
// Reset (synchronous, active high) clears all valid bits; items in flight are dropped.
// Results cannot be stalled: each appears for one cycle with done high.
module complex_arithmetic_unit #(
  parameter int DATA_WIDTH = 16,
  parameter int FRAC_BITS  = 12
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  output logic                                 busy,
  input  logic [cau_pkg::KIND_W-1:0]           kind,
  input  logic signed [DATA_WIDTH-1:0]         a_re,
  input  logic signed [DATA_WIDTH-1:0]         a_im,
  input  logic signed [DATA_WIDTH-1:0]         b_re,
  input  logic signed [DATA_WIDTH-1:0]         b_im,
  output logic                                 done,
  output logic signed [DATA_WIDTH-1:0]         res_re,
  output logic signed [DATA_WIDTH-1:0]         res_im,
  output logic [cau_pkg::STATUS_W-1:0]         status
);

  localparam int W   = DATA_WIDTH;
  localparam int F   = FRAC_BITS;
  localparam int VW  = 2 * W + 1;
  localparam int DW  = 2 * W;
  localparam int NW  = W + 2 * F;
  localparam int RW  = (NW > 3 * W) ? NW : 3 * W;
  localparam int KW  = cau_pkg::KIND_W;
  localparam int SW  = 6 + 2 * W + KW;
  localparam logic [VW-1:0] HALF_V = VW'(1) << (W - 1);
  localparam logic [W-1:0]  MAXP   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MINN   = {1'b1, {(W-1){1'b0}}};

  cau_pkg::cau_ctl_t    in_ctl, c_ctl;
  logic signed [VW-1:0] v_re, v_im;
  logic [DW-1:0]        den_c;
  logic [W-1:0]         amag_re, amag_im;

  // Clamp an exact value, scaled down toward zero for multiply; returns {sat, result}.
  function automatic logic [W:0] clamp_lin(input logic [VW-1:0] v, input logic is_mul);
    logic          neg;
    logic [VW-1:0] mag, shm, negm;
    logic [W:0]    r;
    neg  = v[VW-1];
    mag  = neg ? (VW'(0) - v) : v;
    shm  = is_mul ? (mag >> F) : mag;
    negm = VW'(0) - shm;
    if (neg) begin
      if (shm > HALF_V) r = {1'b1, MINN};
      else              r = {1'b0, negm[W-1:0]};
    end else begin
      if (shm > HALF_V - VW'(1)) r = {1'b1, MAXP};
      else                       r = {1'b0, shm[W-1:0]};
    end
    return r;
  endfunction

  // Clamp a quotient magnitude with its sign; returns {sat, result}.
  function automatic logic [W:0] clamp_q(input logic [W-1:0] q, input logic neg,
                                         input logic big);
    logic [W:0] r;
    if (neg) begin
      if (big || q > MINN) r = {1'b1, MINN};
      else                 r = {1'b0, W'(0) - q};
    end else begin
      if (big || q > MAXP) r = {1'b1, MAXP};
      else                 r = {1'b0, q};
    end
    return r;
  endfunction

  assign busy         = 1'b0;
  assign in_ctl.valid = start;
  assign in_ctl.kind  = kind;

  cau_front #(.W(W)) u_front (
    .clk     (clk),
    .rst     (rst),
    .in_ctl  (in_ctl),
    .a_re    (a_re),
    .a_im    (a_im),
    .b_re    (b_re),
    .b_im    (b_im),
    .out_ctl (c_ctl),
    .v_re    (v_re),
    .v_im    (v_im),
    .den     (den_c),
    .amag_re (amag_re),
    .amag_im (amag_im)
  );

  // Stage D: clamp the non-divide results and prepare the division.
  logic          is_mul;
  logic [W:0]    cl_re, cl_im;
  logic [RW-1:0] num_re, num_im, den_top;
  logic          dz_d, big_re_d, big_im_d, rneg_re_d, rneg_im_d;

  assign is_mul    = c_ctl.kind == cau_pkg::KIND_MUL;
  assign cl_re     = clamp_lin(v_re, is_mul);
  assign cl_im     = clamp_lin(v_im, is_mul);
  assign num_re    = RW'(amag_re) << (2 * F);
  assign num_im    = RW'(amag_im) << (2 * F);
  assign den_top   = RW'(den_c) << W;
  assign dz_d      = den_c == '0;
  assign big_re_d  = num_re >= den_top;
  assign big_im_d  = num_im >= den_top;
  assign rneg_re_d = amag_re != '0 && v_re == '0 && 1'b0;
  assign rneg_im_d = 1'b0;

  // Sign flags of the reciprocal parts come from a's sign, kept by the front as magnitudes,
  // so recover them from the original operand sign carried in a small side register chain.
  logic sa_re_1, sa_im_1, sa_re_2, sa_im_2, sa_re_3, sa_im_3;
  always_ff @(posedge clk) begin
    sa_re_1 <= a_re[W-1];
    sa_im_1 <= (a_im != '0) && !a_im[W-1];
    sa_re_2 <= sa_re_1;
    sa_im_2 <= sa_im_1;
    sa_re_3 <= sa_re_2;
    sa_im_3 <= sa_im_2;
  end

  logic          ch_valid [W+1];
  logic [RW-1:0] ch_rem_re [W+1];
  logic [RW-1:0] ch_rem_im [W+1];
  logic [W-1:0]  ch_q_re [W+1];
  logic [W-1:0]  ch_q_im [W+1];
  logic [DW-1:0] ch_den [W+1];
  logic [SW-1:0] ch_side [W+1];

  always_ff @(posedge clk) begin
    if (rst) begin
      ch_valid[0] <= 1'b0;
    end else begin
      ch_valid[0] <= c_ctl.valid;
    end
    ch_rem_re[0] <= num_re;
    ch_rem_im[0] <= num_im;
    ch_q_re[0]   <= '0;
    ch_q_im[0]   <= '0;
    ch_den[0]    <= den_c;
    ch_side[0]   <= {dz_d, big_re_d, big_im_d, sa_re_3 | rneg_re_d, sa_im_3 | rneg_im_d,
                     cl_re[W] | cl_im[W], cl_re[W-1:0], cl_im[W-1:0], c_ctl.kind};
  end

  // Divider chain: one quotient bit per stage, most significant first.
  for (genvar k = 0; k < W; k++) begin : g_div
    cau_div_step #(.W(W), .RW(RW), .DW(DW), .SHIFT(W - 1 - k), .SW(SW)) u_step (
      .clk        (clk),
      .rst        (rst),
      .in_valid   (ch_valid[k]),
      .in_rem_re  (ch_rem_re[k]),
      .in_rem_im  (ch_rem_im[k]),
      .in_q_re    (ch_q_re[k]),
      .in_q_im    (ch_q_im[k]),
      .in_den     (ch_den[k]),
      .in_side    (ch_side[k]),
      .out_valid  (ch_valid[k+1]),
      .out_rem_re (ch_rem_re[k+1]),
      .out_rem_im (ch_rem_im[k+1]),
      .out_q_re   (ch_q_re[k+1]),
      .out_q_im   (ch_q_im[k+1]),
      .out_den    (ch_den[k+1]),
      .out_side   (ch_side[k+1])
    );
  end

  // Stage E: pick the final result and status.
  logic                 e_dz, e_big_re, e_big_im, e_neg_re, e_neg_im, e_lsat;
  logic [W-1:0]         e_lres_re, e_lres_im;
  logic [KW-1:0]        e_kind;
  logic [W:0]           cq_re, cq_im;
  logic signed [W-1:0]  res_re_next, res_im_next;
  logic [cau_pkg::STATUS_W-1:0] status_next;

  assign {e_dz, e_big_re, e_big_im, e_neg_re, e_neg_im, e_lsat,
          e_lres_re, e_lres_im, e_kind} = ch_side[W];
  assign cq_re = clamp_q(ch_q_re[W], e_neg_re, e_big_re);
  assign cq_im = clamp_q(ch_q_im[W], e_neg_im, e_big_im);

  always_comb begin
    case (e_kind)
      cau_pkg::KIND_RECIP: begin
        if (e_dz) begin
          res_re_next = '0;
          res_im_next = '0;
          status_next = cau_pkg::STATUS_DIV0;
        end else begin
          res_re_next = cq_re[W-1:0];
          res_im_next = cq_im[W-1:0];
          status_next = (cq_re[W] | cq_im[W]) ? cau_pkg::STATUS_SAT : cau_pkg::STATUS_OK;
        end
      end
      default: begin
        res_re_next = e_lres_re;
        res_im_next = e_lres_im;
        status_next = e_lsat ? cau_pkg::STATUS_SAT : cau_pkg::STATUS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= ch_valid[W];
    end
    res_re <= res_re_next;
    res_im <= res_im_next;
    status <= status_next;
  end

endmodule

### design/cau_checker.sv
// Port-level checks of the complex arithmetic unit and their binding to the top level.
module cau_checker #(
  parameter int W   = 16,
  parameter int LAT = 21
) (
  input logic                         clk,
  input logic                         rst,
  input logic                         start,
  input logic                         busy,
  input logic                         done,
  input logic signed [W-1:0]          res_re,
  input logic signed [W-1:0]          res_im,
  input logic [cau_pkg::STATUS_W-1:0] status
);

  localparam int CW = $clog2(LAT + 1);

  logic [CW-1:0] since_rst;

  // Count cycles since reset, stopping at the pipeline latency.
  always_ff @(posedge clk) begin
    if (rst) begin
      since_rst <= '0;
    end else if (since_rst != CW'(LAT)) begin
      since_rst <= since_rst + CW'(1);
    end
  end

  // Every transfer gives exactly one result after the fixed latency.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    since_rst == CW'(LAT) |-> done == $past(start && !busy, LAT))
    else $error("result strobe does not match a transfer");

  // A divide by zero yields zero parts.
  a_div0_zero: assert property (@(posedge clk) disable iff (rst)
    done && status == cau_pkg::STATUS_DIV0 |-> res_re == '0 && res_im == '0)
    else $error("divide by zero with nonzero result");

  // Only defined status codes appear.
  a_status: assert property (@(posedge clk) disable iff (rst)
    done |-> status == cau_pkg::STATUS_OK || status == cau_pkg::STATUS_SAT ||
             status == cau_pkg::STATUS_DIV0)
    else $error("undefined status code");

  // No result strobe is high when reset falls.
  a_reset_quiet: assert property (@(posedge clk)
    $fell(rst) |-> !done)
    else $error("result strobe right after reset");

endmodule

bind complex_arithmetic_unit cau_checker #(.W(DATA_WIDTH), .LAT(DATA_WIDTH + 5)) u_cau_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .done   (done),
  .res_re (res_re),
  .res_im (res_im),
  .status (status)
);
